[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/mi3_pkg.sv]
// ----------------------------------------------------------------------------
// mi3_pkg
// Element selection for the cofactor lanes and the lane status type.
// ----------------------------------------------------------------------------
package mi3_pkg;

    localparam int unsigned NUM_ELEM = 9;
    localparam int unsigned IDX_W    = 4;

    typedef logic [IDX_W-1:0] elem_idx_t;

    // Cofactor k is a[p]*a[q] - a[r]*a[s], elements in row-major order.
    localparam elem_idx_t COF_SEL [NUM_ELEM][4] = '{
        '{4'd4, 4'd8, 4'd7, 4'd5},
        '{4'd2, 4'd7, 4'd1, 4'd8},
        '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd3, 4'd8},
        '{4'd0, 4'd8, 4'd2, 4'd6},
        '{4'd3, 4'd2, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd6, 4'd4},
        '{4'd6, 4'd1, 4'd0, 4'd7},
        '{4'd0, 4'd4, 4'd3, 4'd1}
    };

    typedef struct packed {
        logic neg;
        logic big;
    } quot_flags_t;

endpackage

[src/mi3_cof.sv]
// ----------------------------------------------------------------------------
// mi3_cof
// One 2x2 cofactor lane: two products, then their exact difference.
// ----------------------------------------------------------------------------
module mi3_cof #(
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic signed [DATA_WIDTH-1:0] p,
    input  logic signed [DATA_WIDTH-1:0] q,
    input  logic signed [DATA_WIDTH-1:0] r,
    input  logic signed [DATA_WIDTH-1:0] s,
    output logic signed [2*DATA_WIDTH:0] cof
);

    localparam int unsigned PW = 2 * DATA_WIDTH;

    logic signed [PW-1:0] pq_reg;
    logic signed [PW-1:0] rs_reg;
    logic signed [PW:0]   cof_reg;
    logic signed [PW:0]   cof_next;

    assign cof_next = (PW+1)'(pq_reg) - (PW+1)'(rs_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pq_reg  <= PW'(p * q);
            rs_reg  <= PW'(r * s);
            cof_reg <= cof_next;
        end
    end

    assign cof = cof_reg;

endmodule

[src/mi3_det.sv]
// ----------------------------------------------------------------------------
// mi3_det
// Determinant by expansion along the first row, in three stages.
// ----------------------------------------------------------------------------
module mi3_det #(
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           en,
    input  logic signed [DATA_WIDTH-1:0]   row [3],
    input  logic signed [2*DATA_WIDTH:0]   cof [3],
    output logic signed [3*DATA_WIDTH+2:0] det
);

    localparam int unsigned W  = DATA_WIDTH;
    localparam int unsigned PW = 2 * W + 1;
    localparam int unsigned TW = 3 * W + 1;
    localparam int unsigned DW = 3 * W + 3;

    logic signed [W-1:0]  row_d1_reg [3];
    logic signed [W-1:0]  row_d2_reg [3];
    logic signed [PW-1:0] lo_reg     [3];
    logic signed [PW-1:0] hi_reg     [3];
    logic signed [TW-1:0] term_reg   [3];
    logic signed [TW-1:0] term_next  [3];
    logic signed [DW-1:0] det_reg;
    logic signed [DW-1:0] det_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            term_next[k] = (TW'(hi_reg[k]) <<< W) + TW'(lo_reg[k]);
        end
        det_next = DW'(term_reg[0]) + DW'(term_reg[1]) + DW'(term_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                row_d1_reg[k] <= row[k];
                row_d2_reg[k] <= row_d1_reg[k];
                lo_reg[k]     <= PW'(row_d2_reg[k] * $signed({1'b0, cof[k][W-1:0]}));
                hi_reg[k]     <= PW'(row_d2_reg[k] * $signed(cof[k][2*W:W]));
                term_reg[k]   <= term_next[k];
            end
            det_reg <= det_next;
        end
    end

    assign det = det_reg;

endmodule

[src/mi3_div_lane.sv]
// ----------------------------------------------------------------------------
// mi3_div_lane
// Rounded quotient magnitude of cofactor * 2^(2F) over the determinant,
// one quotient bit per stage.
// ----------------------------------------------------------------------------
module mi3_div_lane #(
    parameter int unsigned DATA_WIDTH = 32,
    parameter int unsigned FRAC_BITS  = 16
) (
    input  logic                           clk,
    input  logic                           en,
    input  logic signed [2*DATA_WIDTH:0]   cof,
    input  logic signed [3*DATA_WIDTH+2:0] det,
    output logic        [DATA_WIDTH-1:0]   mag,
    output mi3_pkg::quot_flags_t           flags
);

    localparam int unsigned W  = DATA_WIDTH;
    localparam int unsigned CW = 2 * W + 1;
    localparam int unsigned DW = 3 * W + 3;
    localparam int unsigned NA = 2 * W + 2 * FRAC_BITS + 2;
    localparam int unsigned NB = DW;
    localparam int unsigned NW = ((NA > NB) ? NA : NB) + 1;

    logic [CW-1:0] c_abs;
    logic [DW-1:0] d_abs;
    logic [NW-1:0] num_next;
    logic [DW:0]   den_next;
    mi3_pkg::quot_flags_t flg_next;

    logic [NW-1:0] rem_reg [0:W-1];
    logic [DW:0]   den_reg [0:W-1];
    logic [W-1:0]  q_reg   [0:W];
    mi3_pkg::quot_flags_t flg_reg [0:W];

    // The rounded quotient is floor((2|n| + |d|) / 2|d|).
    always_comb
    begin
        c_abs        = cof[CW-1] ? CW'(-cof) : CW'(cof);
        d_abs        = det[DW-1] ? DW'(-det) : DW'(det);
        num_next     = (NW'(c_abs) << (2 * FRAC_BITS + 1)) + NW'(d_abs);
        den_next     = {d_abs, 1'b0};
        flg_next.neg = cof[CW-1] != det[DW-1];
        flg_next.big = (num_next >> W) >= NW'(den_next);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num_next;
            den_reg[0] <= den_next;
            q_reg[0]   <= '0;
            flg_reg[0] <= flg_next;
        end
    end

    for (genvar k = 0; k < W; k++)
    begin : g_step
        localparam int unsigned BIT = W - 1 - k;
        logic take;

        assign take = (rem_reg[k] >> BIT) >= NW'(den_reg[k]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[k+1]   <= q_reg[k] | (W'(take) << BIT);
                flg_reg[k+1] <= flg_reg[k];
            end
        end

        if (k < W - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k+1] <= take ? rem_reg[k] - (NW'(den_reg[k]) << BIT)
                                         : rem_reg[k];
                    den_reg[k+1] <= den_reg[k];
                end
            end
        end
    end

    assign mag   = q_reg[W];
    assign flags = flg_reg[W];

endmodule

[src/matrix3_inverse.sv]
// ----------------------------------------------------------------------------
// matrix3_inverse
// Inverse and determinant of a 3x3 signed fixed-point matrix by adjugate.
// ----------------------------------------------------------------------------
//  Channel  | Handshake           | Payload
//  matrix   | mat_valid/mat_stall | a00 .. a22
//  inverse  | inv_valid/inv_stall | r00 .. r22, det_value, singular, overflow
//
// One item is accepted per cycle while mat_stall is low.
// The depth of the pipeline is set by the restoring divider in each of the nine lanes,
// which resolves one quotient bit per stage.
// Reset clears the valid bits of the pipeline and the output valid register.
// A stall on the inverse side freezes the pipeline only when its last stage is full.
// ----------------------------------------------------------------------------
module matrix3_inverse #(
    parameter int unsigned DATA_WIDTH = 32,
    parameter int unsigned FRAC_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         mat_valid,
    output logic                         mat_stall,
    input  logic signed [DATA_WIDTH-1:0] a00,
    input  logic signed [DATA_WIDTH-1:0] a01,
    input  logic signed [DATA_WIDTH-1:0] a02,
    input  logic signed [DATA_WIDTH-1:0] a10,
    input  logic signed [DATA_WIDTH-1:0] a11,
    input  logic signed [DATA_WIDTH-1:0] a12,
    input  logic signed [DATA_WIDTH-1:0] a20,
    input  logic signed [DATA_WIDTH-1:0] a21,
    input  logic signed [DATA_WIDTH-1:0] a22,
    output logic                         inv_valid,
    input  logic                         inv_stall,
    output logic signed [DATA_WIDTH-1:0] r00,
    output logic signed [DATA_WIDTH-1:0] r01,
    output logic signed [DATA_WIDTH-1:0] r02,
    output logic signed [DATA_WIDTH-1:0] r10,
    output logic signed [DATA_WIDTH-1:0] r11,
    output logic signed [DATA_WIDTH-1:0] r12,
    output logic signed [DATA_WIDTH-1:0] r20,
    output logic signed [DATA_WIDTH-1:0] r21,
    output logic signed [DATA_WIDTH-1:0] r22,
    output logic signed [DATA_WIDTH-1:0] det_value,
    output logic                         singular,
    output logic                         overflow
);

    `include "assert_macros.svh"

    localparam int unsigned W    = DATA_WIDTH;
    localparam int unsigned CW   = 2 * W + 1;
    localparam int unsigned DW   = 3 * W + 3;
    localparam int unsigned DE   = DW + 2;
    localparam int unsigned NE   = mi3_pkg::NUM_ELEM;
    localparam int unsigned LAST = W + 6;

    logic                 adv;
    logic                 out_free;
    logic [LAST:0]        v_reg;
    logic signed [W-1:0]  a_reg   [NE];
    logic signed [W-1:0]  a_in    [NE];
    logic signed [CW-1:0] cof_w   [NE];
    logic signed [CW-1:0] c3_reg  [NE];
    logic signed [CW-1:0] c4_reg  [NE];
    logic signed [CW-1:0] c5_reg  [NE];
    logic signed [W-1:0]  row0    [3];
    logic signed [CW-1:0] cof_row [3];
    logic signed [DW-1:0] det_w;
    logic [W-1:0]         mag_w   [NE];
    mi3_pkg::quot_flags_t flg_w   [NE];

    logic [DW-1:0]        d_abs;
    logic [DE-1:0]        d_mag;
    logic [DE-1:0]        d_lim;
    logic [DE-1:0]        d_clip;
    logic                 d_sat_next;
    logic                 d_sing_next;
    logic [W-1:0]         d_val_next;

    logic [W-1:0]         dv_reg   [0:W];
    logic                 dsat_reg [0:W];
    logic                 sing_reg [0:W];

    logic [W-1:0]         q_lim    [NE];
    logic [W-1:0]         q_clip   [NE];
    logic [NE-1:0]        q_sat;
    logic [W-1:0]         r_next   [NE];

    logic                 inv_valid_reg;
    logic signed [W-1:0]  r_reg    [NE];
    logic signed [W-1:0]  det_value_reg;
    logic                 singular_reg;
    logic                 overflow_reg;

    assign out_free  = !inv_valid_reg || !inv_stall;
    assign adv       = !v_reg[LAST] || out_free;
    assign mat_stall = !adv;

    assign a_in[0] = a00;
    assign a_in[1] = a01;
    assign a_in[2] = a02;
    assign a_in[3] = a10;
    assign a_in[4] = a11;
    assign a_in[5] = a12;
    assign a_in[6] = a20;
    assign a_in[7] = a21;
    assign a_in[8] = a22;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[LAST-1:0], mat_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < NE; k++)
            begin
                a_reg[k]  <= a_in[k];
                c3_reg[k] <= cof_w[k];
                c4_reg[k] <= c3_reg[k];
                c5_reg[k] <= c4_reg[k];
            end
        end
    end

    for (genvar k = 0; k < NE; k++)
    begin : g_cof
        mi3_cof #(
            .DATA_WIDTH(DATA_WIDTH)
        ) u_cof (
            .clk (clk),
            .en  (adv),
            .p   (a_reg[mi3_pkg::COF_SEL[k][0]]),
            .q   (a_reg[mi3_pkg::COF_SEL[k][1]]),
            .r   (a_reg[mi3_pkg::COF_SEL[k][2]]),
            .s   (a_reg[mi3_pkg::COF_SEL[k][3]]),
            .cof (cof_w[k])
        );
    end

    assign row0[0]    = a_reg[0];
    assign row0[1]    = a_reg[1];
    assign row0[2]    = a_reg[2];
    assign cof_row[0] = cof_w[0];
    assign cof_row[1] = cof_w[3];
    assign cof_row[2] = cof_w[6];

    mi3_det #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_det (
        .clk (clk),
        .en  (adv),
        .row (row0),
        .cof (cof_row),
        .det (det_w)
    );

    for (genvar k = 0; k < NE; k++)
    begin : g_lane
        mi3_div_lane #(
            .DATA_WIDTH(DATA_WIDTH),
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk   (clk),
            .en    (adv),
            .cof   (c5_reg[k]),
            .det   (det_w),
            .mag   (mag_w[k]),
            .flags (flg_w[k])
        );
    end

    // The determinant output is the exact value scaled down by 2^(2F), rounded and saturated.
    always_comb
    begin
        d_abs       = det_w[DW-1] ? DW'(-det_w) : DW'(det_w);
        d_mag       = ((DE'(d_abs) << 1) + (DE'(1) << (2 * FRAC_BITS))) >> (2 * FRAC_BITS + 1);
        d_lim       = det_w[DW-1] ? (DE'(1) << (W - 1)) : (DE'(1) << (W - 1)) - DE'(1);
        d_sat_next  = d_mag > d_lim;
        d_clip      = d_sat_next ? d_lim : d_mag;
        d_val_next  = det_w[DW-1] ? W'(-d_clip[W-1:0]) : d_clip[W-1:0];
        d_sing_next = det_w == '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_reg[0]   <= d_val_next;
            dsat_reg[0] <= d_sat_next;
            sing_reg[0] <= d_sing_next;
            for (int k = 1; k <= W; k++)
            begin
                dv_reg[k]   <= dv_reg[k-1];
                dsat_reg[k] <= dsat_reg[k-1];
                sing_reg[k] <= sing_reg[k-1];
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < NE; k++)
        begin
            q_lim[k]  = flg_w[k].neg ? (W'(1) << (W - 1)) : (W'(1) << (W - 1)) - W'(1);
            q_sat[k]  = flg_w[k].big || (mag_w[k] > q_lim[k]);
            q_clip[k] = q_sat[k] ? q_lim[k] : mag_w[k];
            r_next[k] = sing_reg[W] ? '0 : (flg_w[k].neg ? W'(-q_clip[k]) : q_clip[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            inv_valid_reg <= v_reg[LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            for (int k = 0; k < NE; k++)
            begin
                r_reg[k] <= r_next[k];
            end
            det_value_reg <= dv_reg[W];
            singular_reg  <= sing_reg[W];
            overflow_reg  <= !sing_reg[W] && ((|q_sat) || dsat_reg[W]);
        end
    end

    assign inv_valid = inv_valid_reg;
    assign r00       = r_reg[0];
    assign r01       = r_reg[1];
    assign r02       = r_reg[2];
    assign r10       = r_reg[3];
    assign r11       = r_reg[4];
    assign r12       = r_reg[5];
    assign r20       = r_reg[6];
    assign r21       = r_reg[7];
    assign r22       = r_reg[8];
    assign det_value = det_value_reg;
    assign singular  = singular_reg;
    assign overflow  = overflow_reg;

    `ASSERT_IMPLY(a_sing_no_ovf, inv_valid_reg && singular_reg, !overflow_reg,
        "singular item flagged overflow")
    `ASSERT_IMPLY(a_sing_zero, inv_valid_reg && singular_reg,
        r_reg[0] == '0 && r_reg[4] == '0 && r_reg[8] == '0 && det_value_reg == '0,
        "singular item has nonzero results")
    `ASSERT_NEXT(a_hold_last, inv_valid_reg && inv_stall && v_reg[LAST], v_reg[LAST],
        "item lost from last stage during stall")
    `ASSERT_NEXT(a_accept_enters, mat_valid && !mat_stall, v_reg[0],
        "accepted item did not enter the pipeline")

endmodule

[tb/matrix3_inverse_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix3_inverse_checker
// Watches both channels of the 3x3 inverse block, computes the exact adjugate,
// determinant and rounded, saturated quotients for every accepted matrix, and
// compares each returned item field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module matrix3_inverse_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               mat_valid,
    input  logic               mat_stall,
    input  logic signed [31:0] a00, a01, a02, a10, a11, a12, a20, a21, a22,
    input  logic               inv_valid,
    input  logic               inv_stall,
    input  logic signed [31:0] r00, r01, r02, r10, r11, r12, r20, r21, r22,
    input  logic signed [31:0] det_value,
    input  logic               singular,
    input  logic               overflow,
    output int                 errors,
    output int                 pending
);

    typedef struct {
        logic [31:0] inv [9];
        logic [31:0] det;
        logic        sing;
        logic        ovf;
    } inverse_t;

    inverse_t expected_inverses [$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH at %0t: %s got %h expected %h", $realtime, what, got, want);
        errors++;
    endtask

    function automatic logic [31:0] round_sat(input logic signed [255:0] num,
                                              input logic signed [255:0] den,
                                              inout logic ovf);
        logic        neg;
        logic [255:0] mag_n, mag_d, q, lim;
        neg   = num[255] ^ den[255];
        mag_n = num[255] ? -num : num;
        mag_d = den[255] ? -den : den;
        q     = (2 * mag_n + mag_d) / (2 * mag_d);
        lim   = neg ? (256'd1 << 31) : ((256'd1 << 31) - 256'd1);
        if (q > lim)
        begin
            ovf = 1'b1;
            q   = lim;
        end
        return neg ? -q[31:0] : q[31:0];
    endfunction

    function automatic inverse_t predict_inverse(input logic signed [31:0] m [9]);
        logic signed [255:0] e [9];
        logic signed [255:0] cof [9];
        logic signed [255:0] det;
        inverse_t            res;
        logic                ovf;
        for (int i = 0; i < 9; i++)
            e[i] = m[i];
        cof[0] = e[4] * e[8] - e[7] * e[5];
        cof[1] = e[2] * e[7] - e[1] * e[8];
        cof[2] = e[1] * e[5] - e[2] * e[4];
        cof[3] = e[5] * e[6] - e[3] * e[8];
        cof[4] = e[0] * e[8] - e[2] * e[6];
        cof[5] = e[3] * e[2] - e[0] * e[5];
        cof[6] = e[3] * e[7] - e[6] * e[4];
        cof[7] = e[6] * e[1] - e[0] * e[7];
        cof[8] = e[0] * e[4] - e[3] * e[1];
        det = e[0] * cof[0] + e[1] * cof[3] + e[2] * cof[6];
        ovf = 1'b0;
        if (det == 0)
        begin
            for (int i = 0; i < 9; i++)
                res.inv[i] = '0;
            res.det  = '0;
            res.sing = 1'b1;
            res.ovf  = 1'b0;
            return res;
        end
        for (int i = 0; i < 9; i++)
            res.inv[i] = round_sat(cof[i] <<< 32, det, ovf);
        res.det  = round_sat(det, 256'sd1 <<< 32, ovf);
        res.sing = 1'b0;
        res.ovf  = ovf;
        return res;
    endfunction

    always @(posedge clk)
    begin
        logic signed [31:0] m [9];
        logic [31:0]        got [9];
        inverse_t           want;
        if (rst_n && mat_valid && !mat_stall)
        begin
            m = '{a00, a01, a02, a10, a11, a12, a20, a21, a22};
            expected_inverses.push_back(predict_inverse(m));
        end
        if (rst_n && inv_valid && !inv_stall)
        begin
            if (expected_inverses.size() == 0)
            begin
                $display("MISMATCH at %0t: result item with nothing expected", $realtime);
                errors++;
            end
            else
            begin
                want = expected_inverses.pop_front();
                got  = '{r00, r01, r02, r10, r11, r12, r20, r21, r22};
                for (int i = 0; i < 9; i++)
                    if (got[i] !== want.inv[i])
                        report_mismatch($sformatf("r%0d%0d", i / 3, i % 3), got[i],
                                        want.inv[i]);
                if (det_value !== want.det)
                    report_mismatch("det_value", det_value, want.det);
                if (singular !== want.sing)
                    report_mismatch("singular", 32'(singular), 32'(want.sing));
                if (overflow !== want.ovf)
                    report_mismatch("overflow", 32'(overflow), 32'(want.ovf));
            end
        end
        pending = expected_inverses.size();
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives matrices into the 3x3 inverse block: directed corner matrices, then
// random small, singular, diagonal, tiny and full-range matrices
// under several idle and stall patterns, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CYCLE_LIMIT = 300000;
    localparam int ONE         = 32'sh0001_0000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               mat_valid = 1'b0;
    logic               mat_stall;
    logic signed [31:0] a00 = '0, a01 = '0, a02 = '0, a10 = '0, a11 = '0;
    logic signed [31:0] a12 = '0, a20 = '0, a21 = '0, a22 = '0;
    logic               inv_valid;
    logic               inv_stall = 1'b0;
    logic signed [31:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
    logic signed [31:0] det_value;
    logic               singular;
    logic               overflow;
    int                 errors;
    int                 pending;

    logic signed [31:0] mat [9];
    int                 send_idle_pct = 0;
    int                 stall_pct = 0;
    bit                 hold_off = 0;
    int                 cycles = 0;
    int                 sent = 0;

    matrix3_inverse dut (.*);
    matrix3_inverse_checker checker_i (.*);

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge clk)
        inv_stall <= hold_off || ($urandom_range(99) < stall_pct);

    task automatic send_matrix();
        if ($urandom_range(99) < send_idle_pct)
        begin
            mat_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        mat_valid <= 1'b1;
        {a00, a01, a02} <= {mat[0], mat[1], mat[2]};
        {a10, a11, a12} <= {mat[3], mat[4], mat[5]};
        {a20, a21, a22} <= {mat[6], mat[7], mat[8]};
        @(posedge clk);
        while (mat_stall)
            @(posedge clk);
        sent++;
    endtask

    task automatic send_fixed(input logic signed [31:0] m [9]);
        mat = m;
        send_matrix();
    endtask

    function automatic logic signed [31:0] small_value();
        return $urandom_range(0, 8 * ONE) - 4 * ONE;
    endfunction

    task automatic random_matrix();
        int kind;
        kind = $urandom_range(9);
        for (int i = 0; i < 9; i++)
            case (kind)
                0, 1:    mat[i] = $urandom;
                7:       mat[i] = (i % 4 == 0) ? ($urandom >> $urandom_range(31)) : 0;
                8:       mat[i] = ($urandom_range(6) - 3) * ONE;
                9:       mat[i] = $urandom_range(16) - 8;
                default: mat[i] = small_value();
            endcase
        if (kind == 6)
            for (int i = 0; i < 3; i++)
                mat[6 + i] = mat[$urandom_range(1) * 3 + i];
        if (kind == 7 && $urandom_range(1))
            mat[4] = -mat[4];
    endtask

    task automatic random_phase(input int count);
        for (int n = 0; n < count; n++)
        begin
            random_matrix();
            send_matrix();
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_fixed('{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE});
        send_fixed('{-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE});
        send_fixed('{0, 0, 0, 0, 0, 0, 0, 0, 0});
        send_fixed('{32'sh7fffffff, 0, 0, 0, 32'sh7fffffff, 0, 0, 0, 32'sh7fffffff});
        send_fixed('{32'sh80000000, 0, 0, 0, 32'sh80000000, 0, 0, 0, 32'sh80000000});
        send_fixed('{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                     32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                     32'sh80000000});
        send_fixed('{-1, -1, -1, -1, -1, -1, -1, -1, -1});
        send_fixed('{1, 0, 0, 0, 1, 0, 0, 0, 1});
        send_fixed('{2 * ONE, 0, 0, 0, 2 * ONE, 0, 0, 0, 2 * ONE});
        send_fixed('{ONE / 2, 0, 0, 0, ONE / 4, 0, 0, 0, 3 * ONE});
        send_fixed('{ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE,
                     7 * ONE, 8 * ONE, 9 * ONE});
        send_fixed('{2 * ONE, ONE, 0, ONE, 2 * ONE, ONE, 0, ONE, 2 * ONE});
        send_fixed('{0, ONE, 0, 0, 0, ONE, ONE, 0, 0});
        send_fixed('{3 * ONE, 0, 0, 0, 3 * ONE, 0, 0, 0, 3 * ONE});
        send_fixed('{ONE, 2 * ONE, 0, 2 * ONE, 4 * ONE, 0, 0, 0, ONE});
        send_fixed('{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                     32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                     32'sh7fffffff});
        send_fixed('{16, 0, 0, 0, 4096, 0, 0, 0, 32'sh10000000});
        send_fixed('{32'sh00008000, 0, 0, 0, ONE, 0, 0, 0, ONE});

        random_phase(250);

        send_idle_pct = 48;
        random_phase(250);

        send_idle_pct = 0;
        stall_pct     = 48;
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
        join_none
        random_phase(250);

        mat_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);

        send_idle_pct = 29;
        stall_pct     = 29;
        random_phase(250);

        mat_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        stall_pct = 0;
        repeat (60) @(posedge clk);

        $display("Sent %0d matrices: corner, singular, diagonal, tiny and full-range cases,",
                 sent);
        $display("with idle sender, stalled receiver, a long hold-off and a drain pause.");
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[sim.f]
+incdir+src
src/mi3_pkg.sv
src/mi3_cof.sv
src/mi3_det.sv
src/mi3_div_lane.sv
src/matrix3_inverse.sv
tb/matrix3_inverse_checker.sv
tb/testbench.sv
